// ===== hw/rtl/sar_pkg.sv =====
`timescale 1ns / 1ps

package sar_pkg;

    // Grid geometry
    localparam int GRID_SIDE = 64;
    localparam int IDX_W     = $clog2(GRID_SIDE);
    // Sweep step runs 0 .. GRID_SIDE+2
    localparam int STEP_W    = $clog2(GRID_SIDE + 3);

    // Cell word: height never exceeds 7 during a sweep
    localparam int H_W    = 3;
    localparam int WORD_W = H_W + 1;
    localparam logic [H_W-1:0] TOPPLE_LIMIT = H_W'(4);

    // Toppling count
    localparam int COUNT_W = 24;
    localparam int SUM_W   = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Per-row topple count tree
    localparam int GRP_SIZE  = 8;
    localparam int GRP_NUM   = (GRID_SIDE + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W     = $clog2(GRP_SIZE + 1);
    localparam int ROW_CNT_W = $clog2(GRID_SIDE + 1);

    // Operation codes (the spare code reads as well)
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_DROP     = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;
    localparam logic [1:0] OP_READ_ALT = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] height_in;
        logic       dead_in;
    } sar_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] topple_count;
        logic [1:0]         height_out;
        logic               dead_out;
    } sar_rsp_t;

    typedef struct packed {
        logic           dead;
        logic [H_W-1:0] height;
    } sar_word_t;

    // Sequencer to column cells
    typedef struct packed {
        logic             clr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] wr_addr;
        logic             ld_en;
        logic [IDX_W-1:0] ld_col;
        sar_word_t        ld_word;
        logic             sw_init;
        logic             sw_proc;
        logic             sw_rd_ok;
        logic             sw_wr;
    } sar_cell_ctl_t;

endpackage

// ===== hw/rtl/sandpile_avalanche_relaxer_core.sv =====
`timescale 1ns / 1ps

// Sandpile relaxer on a 64 x 64 grid of heights 0..3 with a dead mark per cell.
// Request channel (req, req_valid, req_stall): one transaction loads, reads or
// drops a grain on the addressed cell. Response channel (rsp, rsp_valid,
// rsp_stall): one transaction per request with the toppling count and the
// cell's height and dead mark after the operation.
// The grid is a row of 64 column cells, each with its own column memory. An
// avalanche is relaxed by row sweeps: each cycle every column works on one row
// and passes its topple bit to both neighbours. Sweeps repeat until one passes
// with no toppling.
// One transaction is worked on at a time; the next is taken once the result
// sits in the output register, even while stalled.
// After reset the grid is cleared row by row with req_stall high.
// A stalled result holds in the output register; a finished next result
// waits inside the block until that register frees.
module sandpile_avalanche_relaxer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sar_pkg::sar_req_t req,
    input  logic              req_valid,
    output logic              req_stall,
    output sar_pkg::sar_rsp_t rsp,
    output logic              rsp_valid,
    input  logic              rsp_stall
);

    import sar_pkg::*;

    sar_cell_ctl_t                  cell_ctl;
    sar_word_t [GRID_SIDE-1:0]      col_words;
    logic [GRID_SIDE-1:0]           topple_vec;
    logic                           topple_any;
    logic                           tally_clr;
    logic [COUNT_W-1:0]             tally_count;

    // Row of column cells
    for (genvar j = 0; j < GRID_SIDE; j++)
    begin : g_col
        logic ld_sel;
        logic t_left;
        logic t_right;

        assign ld_sel = cell_ctl.ld_en && (cell_ctl.ld_col == IDX_W'(j));

        if (j == 0)
        begin : g_first
            assign t_left = 1'b0;
        end
        else
        begin : g_left
            assign t_left = topple_vec[j-1];
        end

        if (j == GRID_SIDE - 1)
        begin : g_last
            assign t_right = 1'b0;
        end
        else
        begin : g_right
            assign t_right = topple_vec[j+1];
        end

        sar_cell u_cell (
            .clk          (clk),
            .ctl          (cell_ctl),
            .ld_sel       (ld_sel),
            .topple_left  (t_left),
            .topple_right (t_right),
            .topple       (topple_vec[j]),
            .rd_word      (col_words[j])
        );
    end

    assign topple_any = |topple_vec;

    sar_tally u_tally (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (tally_clr),
        .topple_vec (topple_vec),
        .count      (tally_count)
    );

    sar_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .rsp         (rsp),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .cell_ctl    (cell_ctl),
        .col_words   (col_words),
        .topple_any  (topple_any),
        .tally_clr   (tally_clr),
        .tally_count (tally_count)
    );

`ifndef SYNTH
    // Topplings only while a transaction is in work
    a_topple_busy: assert property (@(posedge clk) disable iff (!rst_n)
        topple_any |-> req_stall)
        else $error("toppling with request side open");

    // An avalanche starts from a quiet grid
    a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        tally_clr |-> !topple_any)
        else $error("tally cleared during toppling");

    // The running count only grows between clears
    a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !tally_clr |=> (tally_count >= $past(tally_count)))
        else $error("toppling count went down");

    // A result only follows work that held the request side
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without work");
`endif

endmodule

// ===== hw/rtl/sar_ram.sv =====
`timescale 1ns / 1ps

module sar_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sar_cell.sv =====
`timescale 1ns / 1ps

// One grid column: column memory plus a two-row window used by the sweep
module sar_cell (
    input  logic                   clk,
    input  sar_pkg::sar_cell_ctl_t ctl,
    input  logic                   ld_sel,
    input  logic                   topple_left,
    input  logic                   topple_right,
    output logic                   topple,
    output sar_pkg::sar_word_t     rd_word
);

    import sar_pkg::*;

    sar_word_t cur_reg;
    sar_word_t cur_next;
    sar_word_t prev_reg;
    sar_word_t prev_next;
    sar_word_t settled;
    sar_word_t fed;
    sar_word_t wr_word;
    sar_word_t ram_rd;
    logic      wr_en;

    sar_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GRID_SIDE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ctl.wr_addr),
        .wr_data (wr_word),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .rd_data (ram_rd)
    );

    assign rd_word = ram_rd;

    always_comb
    begin
        // Current row: topple decision and grains from the row neighbours
        topple  = ctl.sw_proc && !cur_reg.dead && (cur_reg.height >= TOPPLE_LIMIT);
        settled = cur_reg;
        if (!cur_reg.dead)
        begin
            settled.height = cur_reg.height - (topple ? TOPPLE_LIMIT : '0)
                           + H_W'(topple_left) + H_W'(topple_right);
        end

        // Next row arrives from memory and takes one grain downwards
        fed = ram_rd;
        if (!fed.dead)
        begin
            fed.height = fed.height + H_W'(topple);
        end

        // Row above takes one grain upwards, then goes back to memory
        wr_word = prev_reg;
        if (!prev_reg.dead)
        begin
            wr_word.height = prev_reg.height + H_W'(topple);
        end
        if (ctl.clr)
        begin
            wr_word = '0;
        end
        else if (ld_sel)
        begin
            wr_word = ctl.ld_word;
        end
        wr_en = ctl.clr || ld_sel || ctl.sw_wr;

        // Window shift
        cur_next  = cur_reg;
        prev_next = prev_reg;
        if (ctl.sw_init)
        begin
            cur_next = '0;
        end
        else if (ctl.sw_proc)
        begin
            prev_next = settled;
            cur_next  = ctl.sw_rd_ok ? fed : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
    end

endmodule

// ===== hw/rtl/sar_tally.sv =====
`timescale 1ns / 1ps

// Registered popcount of each row's topplings and saturating accumulator
module sar_tally (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clr,
    input  logic [sar_pkg::GRID_SIDE-1:0]   topple_vec,
    output logic [sar_pkg::COUNT_W-1:0]     count
);

    import sar_pkg::*;

    logic [GRP_W-1:0]     grp_reg  [GRP_NUM];
    logic [GRP_W-1:0]     grp_next [GRP_NUM];
    logic [ROW_CNT_W-1:0] row_reg;
    logic [ROW_CNT_W-1:0] row_next;
    logic [COUNT_W-1:0]   acc_reg;
    logic [COUNT_W-1:0]   acc_next;
    logic [SUM_W-1:0]     acc_sum;

    always_comb
    begin
        // Stage one: groups of eight cells
        for (int g = 0; g < GRP_NUM; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++)
            begin
                if (g * GRP_SIZE + b < GRID_SIDE)
                begin
                    grp_next[g] = grp_next[g] + GRP_W'(topple_vec[g * GRP_SIZE + b]);
                end
            end
        end

        // Stage two: whole row
        row_next = '0;
        for (int g = 0; g < GRP_NUM; g++)
        begin
            row_next = row_next + ROW_CNT_W'(grp_reg[g]);
        end

        // Stage three: saturating running total
        acc_sum  = {1'b0, acc_reg} + SUM_W'(row_reg);
        acc_next = acc_sum[COUNT_W] ? COUNT_MAX : acc_sum[COUNT_W-1:0];
        if (clr)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GRP_NUM; g++)
            begin
                grp_reg[g] <= '0;
            end
            row_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            grp_reg <= grp_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
        end
    end

    assign count = acc_reg;

endmodule

// ===== hw/rtl/sar_ctrl.sv =====
`timescale 1ns / 1ps

// Transaction sequencer: clearing pass, cell access, relaxation sweeps, result register
module sar_ctrl (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  sar_pkg::sar_req_t                             req,
    input  logic                                          req_valid,
    output logic                                          req_stall,
    output sar_pkg::sar_rsp_t                             rsp,
    output logic                                          rsp_valid,
    input  logic                                          rsp_stall,
    output sar_pkg::sar_cell_ctl_t                        cell_ctl,
    input  sar_pkg::sar_word_t [sar_pkg::GRID_SIDE-1:0]   col_words,
    input  logic                                          topple_any,
    output logic                                          tally_clr,
    input  logic [sar_pkg::COUNT_W-1:0]                   tally_count
);

    import sar_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_LOOK,
        ST_SWEEP,
        ST_REPORT
    } state_t;

    state_t           state_reg;
    sar_req_t         item_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic             any_reg;
    logic             post_reg;
    sar_rsp_t         res_reg;
    sar_rsp_t         rsp_reg;
    logic             rsp_valid_reg;

    logic             in_grid;
    logic [IDX_W-1:0] row_idx;
    logic [IDX_W-1:0] col_idx;
    sar_word_t        sel_word;
    logic [H_W-1:0]   h_inc;
    logic             start_sweep;
    logic             sweep_last;
    sar_rsp_t         look_res;
    logic             rsp_load;

    // Addressing and decisions on the held transaction
    always_comb
    begin
        in_grid     = (int'(item_reg.row) < GRID_SIDE) && (int'(item_reg.col) < GRID_SIDE);
        row_idx     = IDX_W'(item_reg.row);
        col_idx     = IDX_W'(item_reg.col);
        sel_word    = col_words[col_idx];
        h_inc       = sel_word.height + H_W'(1);
        start_sweep = (state_reg == ST_LOOK) && in_grid && !post_reg
                   && (item_reg.op == OP_DROP) && !sel_word.dead
                   && (h_inc >= TOPPLE_LIMIT);
        sweep_last  = (step_reg == STEP_W'(GRID_SIDE + 2));
        rsp_load    = (state_reg == ST_REPORT) && (!rsp_valid_reg || !rsp_stall);
    end

    // Result of the held transaction once the addressed row is in view
    always_comb
    begin
        look_res = '0;
        if (in_grid)
        begin
            if (post_reg)
            begin
                look_res.topple_count = tally_count;
                look_res.height_out   = sel_word.height[1:0];
                look_res.dead_out     = sel_word.dead;
            end
            else
            begin
                unique case (item_reg.op) inside
                    OP_LOAD:
                    begin
                        look_res.height_out = item_reg.height_in;
                        look_res.dead_out   = item_reg.dead_in;
                    end
                    OP_DROP:
                    begin
                        if (sel_word.dead)
                        begin
                            look_res.height_out = sel_word.height[1:0];
                            look_res.dead_out   = 1'b1;
                        end
                        else
                        begin
                            look_res.height_out = h_inc[1:0];
                        end
                    end
                    OP_READ, OP_READ_ALT:
                    begin
                        look_res.height_out = sel_word.height[1:0];
                        look_res.dead_out   = sel_word.dead;
                    end
                endcase
            end
        end
    end

    // Cell control
    always_comb
    begin
        cell_ctl = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cell_ctl.clr     = 1'b1;
                cell_ctl.wr_addr = clr_idx_reg;
            end
            ST_ISSUE:
            begin
                cell_ctl.rd_en   = 1'b1;
                cell_ctl.rd_addr = row_idx;
            end
            ST_LOOK:
            begin
                cell_ctl.wr_addr = row_idx;
                cell_ctl.ld_col  = col_idx;
                if (in_grid && !post_reg)
                begin
                    if (item_reg.op == OP_LOAD)
                    begin
                        cell_ctl.ld_en          = 1'b1;
                        cell_ctl.ld_word.dead   = item_reg.dead_in;
                        cell_ctl.ld_word.height = H_W'(item_reg.height_in);
                    end
                    else if ((item_reg.op == OP_DROP) && !sel_word.dead)
                    begin
                        cell_ctl.ld_en          = 1'b1;
                        cell_ctl.ld_word.dead   = 1'b0;
                        cell_ctl.ld_word.height = h_inc;
                    end
                end
            end
            ST_SWEEP:
            begin
                // Step s reads row s, works on row s-2, writes back row s-3
                cell_ctl.sw_init  = (step_reg == '0);
                cell_ctl.sw_proc  = (step_reg != '0);
                cell_ctl.sw_rd_ok = (step_reg != '0) && (step_reg <= STEP_W'(GRID_SIDE));
                cell_ctl.rd_en    = (step_reg < STEP_W'(GRID_SIDE));
                cell_ctl.rd_addr  = step_reg[IDX_W-1:0];
                cell_ctl.sw_wr    = (step_reg >= STEP_W'(3));
                cell_ctl.wr_addr  = IDX_W'(step_reg - STEP_W'(3));
            end
            default:
            begin
                cell_ctl = '0;
            end
        endcase
    end

    assign tally_clr = start_sweep;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            item_reg      <= '0;
            clr_idx_reg   <= '0;
            step_reg      <= '0;
            any_reg       <= 1'b0;
            post_reg      <= 1'b0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Output register: refill from the finished result or empty on take
            if (rsp_load)
            begin
                rsp_reg       <= res_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    if (clr_idx_reg == IDX_W'(GRID_SIDE - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg  <= req;
                        post_reg  <= 1'b0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    if (start_sweep)
                    begin
                        state_reg <= ST_SWEEP;
                        step_reg  <= '0;
                        any_reg   <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_REPORT;
                        res_reg   <= look_res;
                    end
                end
                ST_SWEEP:
                begin
                    if (sweep_last)
                    begin
                        // A sweep without any toppling means the grid is stable
                        step_reg <= '0;
                        any_reg  <= 1'b0;
                        if (!(any_reg || topple_any))
                        begin
                            post_reg  <= 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                    else
                    begin
                        any_reg  <= any_reg | topple_any;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_REPORT:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
